>>> sv/rtte_pkg.sv
// Shared types, register indexes and defaults for the RTT timeout estimator.
package rtte_pkg;

  localparam int unsigned MsWidth = 24;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [MsWidth-1:0] DefaultMinRto = MsWidth'(200);
  localparam logic [MsWidth-1:0] DefaultMaxRto = MsWidth'(60000);
  localparam logic [MsWidth-1:0] DefaultRto    = MsWidth'(1000);

  typedef logic [MsWidth-1:0] ms_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_INITIAL_RTO = 2'd0,
    CFG_MIN_RTO     = 2'd1,
    CFG_MAX_RTO     = 2'd2
  } cfg_idx_e;

  // Effective settings handed from the register block to the datapath.
  typedef struct packed {
    logic restart;
    ms_t  init_rto;
    ms_t  min_rto;
    ms_t  max_rto;
  } cfg_t;

endpackage

>>> sv/rtt_retransmit_timeout_estimator.sv
// Top level: request register, estimator update and result register.
// Path: request accept into the input register, estimator update, then the result register.
// Throughput: one request per cycle while the result side is ready; the state update is combinational.
// Input and result registers stall together when the result side is not ready.
// Reset: asynchronous, active low; clears config (defaults in force) and estimator state,
// timeout starts at the clamped default initial value. Config writes restart the same way.
module rtt_retransmit_timeout_estimator #(
  parameter rtte_pkg::ms_t InitRtoDefault = rtte_pkg::DefaultRto,
  parameter rtte_pkg::ms_t MinRtoDefault  = rtte_pkg::DefaultMinRto,
  parameter rtte_pkg::ms_t MaxRtoDefault  = rtte_pkg::DefaultMaxRto
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rtte_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [rtte_pkg::MsWidth-1:0]          cfg_wdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [23:0]                           s_axis_tdata_i,  // [23:0] sample_ms
  input  logic                                  s_axis_tuser_i,  // [0] func
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [23:0] timeout_ms, [47:24] smoothed_ms, [71:48] variation_ms
  output logic [71:0]                           m_axis_tdata_o,
  output logic                                  m_axis_tuser_o   // [0] estimate_valid
);
  import rtte_pkg::*;

  cfg_t cfg;

  logic in_valid_q;
  logic in_func_q;
  ms_t  in_sample_q;
  logic out_valid_q;
  ms_t  out_tmo_q, out_srtt_q, out_var_q;
  logic out_have_q;

  logic out_ready;
  logic fire;
  ms_t  res_tmo, res_srtt, res_var;
  logic res_have;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;

  rtte_cfg #(
    .InitRtoDefault (InitRtoDefault),
    .MinRtoDefault  (MinRtoDefault),
    .MaxRtoDefault  (MaxRtoDefault)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rtte_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .func_i      (in_func_q),
    .sample_i    (in_sample_q),
    .timeout_o   (res_tmo),
    .smoothed_o  (res_srtt),
    .variation_o (res_var),
    .valid_o     (res_have)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_func_q   <= s_axis_tuser_i;
      in_sample_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_tmo_q  <= res_tmo;
      out_srtt_q <= res_srtt;
      out_var_q  <= res_var;
      out_have_q <= res_have;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_var_q, out_srtt_q, out_tmo_q};
  assign m_axis_tuser_o  = out_have_q;

endmodule

>>> sv/rtte_cfg.sv
// Configuration registers with default substitution and estimator restart.
module rtte_cfg #(
  parameter rtte_pkg::ms_t InitRtoDefault = rtte_pkg::DefaultRto,
  parameter rtte_pkg::ms_t MinRtoDefault  = rtte_pkg::DefaultMinRto,
  parameter rtte_pkg::ms_t MaxRtoDefault  = rtte_pkg::DefaultMaxRto
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rtte_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [rtte_pkg::MsWidth-1:0]          cfg_wdata_i,
  output rtte_pkg::cfg_t                        cfg_o
);
  import rtte_pkg::*;

  ms_t  init_q, min_q, max_q;
  logic hit;

  always_comb begin
    hit = 1'b0;
    case (cfg_idx_i)
      CFG_INITIAL_RTO, CFG_MIN_RTO, CFG_MAX_RTO: hit = cfg_we_i;
      default:                                   hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INITIAL_RTO: init_q <= cfg_wdata_i;
        CFG_MIN_RTO:     min_q  <= cfg_wdata_i;
        CFG_MAX_RTO:     max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero in a register selects the built-in default
  assign cfg_o.restart  = hit;
  assign cfg_o.init_rto = (init_q == '0) ? InitRtoDefault : init_q;
  assign cfg_o.min_rto  = (min_q  == '0) ? MinRtoDefault  : min_q;
  assign cfg_o.max_rto  = (max_q  == '0) ? MaxRtoDefault  : max_q;

endmodule

>>> sv/rtte_core.sv
// Estimator state and combinational SRTT/RTTVAR/RTO update.
module rtte_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtte_pkg::cfg_t                cfg_i,
  input  logic                          fire_i,
  input  logic                          func_i,
  input  logic [rtte_pkg::MsWidth-1:0]  sample_i,
  output logic [rtte_pkg::MsWidth-1:0]  timeout_o,
  output logic [rtte_pkg::MsWidth-1:0]  smoothed_o,
  output logic [rtte_pkg::MsWidth-1:0]  variation_o,
  output logic                          valid_o
);
  import rtte_pkg::*;

  ms_t  srtt_q, srtt_d;
  ms_t  var_q, var_d;
  ms_t  tmo_q, tmo_d;
  logic have_q, have_d;
  logic fresh_q;   // timeout still equals the clamped initial value

  ms_t                cur_tmo;
  ms_t                diff;
  logic [MsWidth+2:0] var_sum;
  logic [MsWidth:0]   var_new;
  logic [MsWidth+3:0] srtt_sum;
  ms_t                var_first;
  logic [MsWidth+2:0] rto_sum;
  logic [MsWidth:0]   dbl;

  function automatic ms_t clamp(input logic [MsWidth+2:0] v, input ms_t lo, input ms_t hi);
    logic [MsWidth+2:0] t;
    t = v;
    if (t < {3'b000, lo}) t = {3'b000, lo};
    if (t > {3'b000, hi}) t = {3'b000, hi};
    return t[MsWidth-1:0];
  endfunction

  always_comb begin
    cur_tmo   = fresh_q ? clamp({3'b000, cfg_i.init_rto}, cfg_i.min_rto, cfg_i.max_rto)
                        : tmo_q;
    diff      = (srtt_q >= sample_i) ? srtt_q - sample_i : sample_i - srtt_q;
    var_sum   = {3'b000, var_q} + {2'b00, var_q, 1'b0} + {3'b000, diff};
    var_new   = var_sum[MsWidth+2:2];
    if (var_new == '0) var_new = (MsWidth+1)'(1);
    srtt_sum  = {1'b0, srtt_q, 3'b000} - {4'b0000, srtt_q} + {4'b0000, sample_i};
    var_first = {1'b0, sample_i[MsWidth-1:1]};
    if (var_first == '0) var_first = MsWidth'(1);

    srtt_d = srtt_q;
    var_d  = var_q;
    have_d = have_q;
    tmo_d  = cur_tmo;
    if (!func_i) begin
      have_d = 1'b1;
      if (!have_q) begin
        srtt_d = sample_i;
        var_d  = var_first;
      end else begin
        srtt_d = srtt_sum[MsWidth+2:3];
        var_d  = var_new[MsWidth-1:0];
      end
      rto_sum = {3'b000, srtt_d} + {1'b0, var_d, 2'b00};
      tmo_d   = clamp(rto_sum, cfg_i.min_rto, cfg_i.max_rto);
      dbl     = '0;
    end else begin
      rto_sum = '0;
      dbl     = {cur_tmo, 1'b0};
      // doubling saturates at the maximum only
      tmo_d   = (dbl > {1'b0, cfg_i.max_rto}) ? cfg_i.max_rto : dbl[MsWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srtt_q  <= '0;
      var_q   <= '0;
      tmo_q   <= '0;
      have_q  <= 1'b0;
      fresh_q <= 1'b1;
    end else if (cfg_i.restart) begin
      srtt_q  <= '0;
      var_q   <= '0;
      have_q  <= 1'b0;
      fresh_q <= 1'b1;
    end else if (fire_i) begin
      srtt_q  <= srtt_d;
      var_q   <= var_d;
      tmo_q   <= tmo_d;
      have_q  <= have_d;
      fresh_q <= 1'b0;
    end
  end

  assign timeout_o   = tmo_d;
  assign smoothed_o  = srtt_d;
  assign variation_o = var_d;
  assign valid_o     = have_d;

endmodule
